/* sv/jsu_pkg.sv */
package jsu_pkg;

	// default depth of the group queue between parser and serializer
	localparam int JSU_QDEPTH = 4;

	// characters the parser looks for
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_LC_B = 8'h62;
	localparam logic [7:0] CH_LC_F = 8'h66;
	localparam logic [7:0] CH_LC_N = 8'h6E;
	localparam logic [7:0] CH_LC_R = 8'h72;
	localparam logic [7:0] CH_LC_T = 8'h74;
	localparam logic [7:0] CH_LC_U = 8'h75;

	// surrogate ranges
	localparam logic [15:0] HI_SURR_LO = 16'hD800;
	localparam logic [15:0] HI_SURR_HI = 16'hDBFF;
	localparam logic [15:0] LO_SURR_LO = 16'hDC00;
	localparam logic [15:0] LO_SURR_HI = 16'hDFFF;

	// utf-8 range limits and lead/continuation marks
	localparam logic [20:0] CP_MAX1 = 21'h00007F;
	localparam logic [20:0] CP_MAX2 = 21'h0007FF;
	localparam logic [20:0] CP_MAX3 = 21'h00FFFF;
	localparam logic [7:0] LEAD2 = 8'hC0;
	localparam logic [7:0] LEAD3 = 8'hE0;
	localparam logic [7:0] LEAD4 = 8'hF0;
	localparam logic [7:0] CONT = 8'h80;

	typedef enum logic [1:0] {
		KIND_DATA  = 2'd0,
		KIND_CLOSE = 2'd1,
		KIND_ERR   = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ERR_NONE     = 3'd0,
		ERR_NO_QUOTE = 3'd1,
		ERR_UNK_ESC  = 3'd2,
		ERR_BAD_HEX  = 3'd3,
		ERR_MISS_U   = 3'd4,
		ERR_BAD_LOW  = 3'd5,
		ERR_END      = 3'd6
	} err_t;

	// all results caused by one input byte, serialized by the back end
	typedef struct packed {
		logic [1:0]      cnt_m1;   // number of results minus one
		logic [3:0][7:0] bytes;    // bytes[0] goes out first
		kind_t           kind;
		err_t            code;
	} grp_t;

endpackage

/* sv/jsu_if.sv */
interface jsu_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       text_end;

	modport source(output valid, output data_byte, output text_end, input ready);
	modport sink(input valid, input data_byte, input text_end, output ready);
endinterface

interface jsu_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic [1:0] kind;
	logic [2:0] error_code;
	logic       last;

	modport source(output valid, output out_byte, output kind, output error_code,
		output last, input ready);
	modport sink(input valid, input out_byte, input kind, input error_code,
		input last, output ready);
endinterface

/* sv/jsu_front.sv */
module jsu_front
	import jsu_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	jsu_in_if.sink in_ch,
	input  logic  q_full,
	output logic  push,
	output grp_t  grp
);

	typedef enum logic [3:0] {
		PH_IDLE = 4'd0,
		PH_STR  = 4'd1,
		PH_ESC  = 4'd2,
		PH_HEX1 = 4'd3,
		PH_BS   = 4'd4,
		PH_U    = 4'd5,
		PH_HEX2 = 4'd6
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [1:0]  hcnt_q, hcnt_d;
	logic [15:0] hacc_q, hacc_d;
	logic [15:0] hsur_q, hsur_d;

	logic        acc;
	logic        push_c;
	grp_t        grp_c;
	logic        err;
	err_t        ecode;
	logic [4:0]  hv;
	logic [15:0] acc_sh;
	logic [10:0] plane;
	logic [20:0] cp_pair;

	// bit 4 flags a non-hex character
	function automatic logic [4:0] hex_val(input logic [7:0] c);
		logic [4:0] r;
		r = 5'h10;
		if (c >= 8'h30 && c <= 8'h39) r = {1'b0, c[3:0]};
		else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
			r = {1'b0, 4'(c[3:0] + 4'd9)};
		return r;
	endfunction

	function automatic grp_t utf8(input logic [20:0] cp);
		grp_t g;
		g = '0;
		g.kind = KIND_DATA;
		g.code = ERR_NONE;
		if (cp <= CP_MAX1) begin
			g.cnt_m1 = 2'd0;
			g.bytes[0] = cp[7:0];
		end else if (cp <= CP_MAX2) begin
			g.cnt_m1 = 2'd1;
			g.bytes[0] = LEAD2 | {3'b0, cp[10:6]};
			g.bytes[1] = CONT | {2'b0, cp[5:0]};
		end else if (cp <= CP_MAX3) begin
			g.cnt_m1 = 2'd2;
			g.bytes[0] = LEAD3 | {4'b0, cp[15:12]};
			g.bytes[1] = CONT | {2'b0, cp[11:6]};
			g.bytes[2] = CONT | {2'b0, cp[5:0]};
		end else begin
			g.cnt_m1 = 2'd3;
			g.bytes[0] = LEAD4 | {5'b0, cp[20:18]};
			g.bytes[1] = CONT | {2'b0, cp[17:12]};
			g.bytes[2] = CONT | {2'b0, cp[11:6]};
			g.bytes[3] = CONT | {2'b0, cp[5:0]};
		end
		return g;
	endfunction

	assign in_ch.ready = !q_full;
	assign acc = in_ch.valid && in_ch.ready;

	assign hv = hex_val(in_ch.data_byte);
	assign acc_sh = {hacc_q[11:0], hv[3:0]};
	// pair code point: 0x10000 + (high - 0xD800) << 10 + (low - 0xDC00)
	assign plane = {1'b0, hsur_q[9:0]} + 11'd64;
	assign cp_pair = {plane[10:0], acc_sh[9:0]};

	always_comb begin
		phase_d = phase_q;
		hcnt_d = hcnt_q;
		hacc_d = hacc_q;
		hsur_d = hsur_q;
		push_c = 1'b0;
		grp_c = '0;
		grp_c.kind = KIND_DATA;
		grp_c.code = ERR_NONE;
		err = 1'b0;
		ecode = ERR_NONE;

		if (phase_q != PH_IDLE && in_ch.text_end) begin
			err = 1'b1;
			ecode = ERR_END;
		end else begin
			case (phase_q)
				PH_STR: begin
					if (in_ch.data_byte == CH_QUOTE) begin
						phase_d = PH_IDLE;
						push_c = 1'b1;
						grp_c.kind = KIND_CLOSE;
					end else if (in_ch.data_byte == CH_BSLASH) begin
						phase_d = PH_ESC;
					end else begin
						push_c = 1'b1;
						grp_c.bytes[0] = in_ch.data_byte;
					end
				end
				PH_ESC: begin
					push_c = 1'b1;
					phase_d = PH_STR;
					case (in_ch.data_byte)
						CH_QUOTE, CH_BSLASH, CH_SLASH: grp_c.bytes[0] = in_ch.data_byte;
						CH_LC_B: grp_c.bytes[0] = 8'h08;
						CH_LC_F: grp_c.bytes[0] = 8'h0C;
						CH_LC_N: grp_c.bytes[0] = 8'h0A;
						CH_LC_R: grp_c.bytes[0] = 8'h0D;
						CH_LC_T: grp_c.bytes[0] = 8'h09;
						CH_LC_U: begin
							push_c = 1'b0;
							phase_d = PH_HEX1;
							hcnt_d = 2'd0;
							hacc_d = '0;
						end
						default: begin
							push_c = 1'b0;
							err = 1'b1;
							ecode = ERR_UNK_ESC;
						end
					endcase
				end
				PH_HEX1: begin
					if (hv[4]) begin
						err = 1'b1;
						ecode = ERR_BAD_HEX;
					end else begin
						hacc_d = acc_sh;
						if (hcnt_q == 2'd3) begin
							hcnt_d = 2'd0;
							if (acc_sh >= HI_SURR_LO && acc_sh <= HI_SURR_HI) begin
								hsur_d = acc_sh;
								hacc_d = '0;
								phase_d = PH_BS;
							end else begin
								phase_d = PH_STR;
								push_c = 1'b1;
								grp_c = utf8({5'b0, acc_sh});
							end
						end else begin
							hcnt_d = hcnt_q + 2'd1;
						end
					end
				end
				PH_BS: begin
					if (in_ch.data_byte != CH_BSLASH) begin
						err = 1'b1;
						ecode = ERR_MISS_U;
					end else begin
						phase_d = PH_U;
					end
				end
				PH_U: begin
					if (in_ch.data_byte != CH_LC_U) begin
						err = 1'b1;
						ecode = ERR_MISS_U;
					end else begin
						phase_d = PH_HEX2;
						hcnt_d = 2'd0;
						hacc_d = '0;
					end
				end
				PH_HEX2: begin
					if (hv[4]) begin
						err = 1'b1;
						ecode = ERR_BAD_HEX;
					end else begin
						hacc_d = acc_sh;
						if (hcnt_q == 2'd3) begin
							hcnt_d = 2'd0;
							if (acc_sh < LO_SURR_LO || acc_sh > LO_SURR_HI) begin
								err = 1'b1;
								ecode = ERR_BAD_LOW;
							end else begin
								phase_d = PH_STR;
								hsur_d = '0;
								push_c = 1'b1;
								grp_c = utf8(cp_pair);
							end
						end else begin
							hcnt_d = hcnt_q + 2'd1;
						end
					end
				end
				default: begin
					// waiting for the opening quote
					if (!in_ch.text_end && in_ch.data_byte == CH_QUOTE) begin
						phase_d = PH_STR;
					end else begin
						err = 1'b1;
						ecode = ERR_NO_QUOTE;
					end
				end
			endcase
		end

		if (err) begin
			phase_d = PH_IDLE;
			hcnt_d = 2'd0;
			hacc_d = '0;
			hsur_d = '0;
			push_c = 1'b1;
			grp_c = '0;
			grp_c.kind = KIND_ERR;
			grp_c.code = ecode;
		end
	end

	assign push = acc && push_c;
	assign grp = grp_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			hcnt_q <= 2'd0;
			hacc_q <= '0;
			hsur_q <= '0;
		end else if (acc) begin
			phase_q <= phase_d;
			hcnt_q <= hcnt_d;
			hacc_q <= hacc_d;
			hsur_q <= hsur_d;
		end
	end

`ifndef SYNTHESIS
	// an error always carries a code and stands alone
	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		push && grp.kind == KIND_ERR |-> grp.code != ERR_NONE && grp.cnt_m1 == 2'd0)
		else $error("error group without code or with several results");
`endif

endmodule

/* sv/jsu_queue.sv */
module jsu_queue
	import jsu_pkg::*;
#(
	parameter int DEPTH = JSU_QDEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  grp_t wr_data,
	input  logic pop,
	output grp_t rd_data,
	output logic full,
	output logic empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	grp_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_ptr_q <= wrap_inc(wr_ptr_q);
			if (pop) rd_ptr_q <= wrap_inc(rd_ptr_q);
			if (push && !pop) count_q <= count_q + CW'(1);
			else if (pop && !push) count_q <= count_q - CW'(1);
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("push into full group queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> !pop)
		else $error("pop from empty group queue");
`endif

endmodule

/* sv/jsu_back.sv */
module jsu_back
	import jsu_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     q_empty,
	input  grp_t     q_data,
	output logic     pop,
	jsu_out_if.source out_ch
);

	grp_t       cur_q;
	logic       cur_v_q;
	logic [1:0] idx_q;
	logic       at_end;
	logic       out_acc;

	assign at_end = (idx_q == cur_q.cnt_m1);
	assign out_acc = out_ch.valid && out_ch.ready;
	assign pop = !q_empty && (!cur_v_q || (out_acc && at_end));

	assign out_ch.valid = cur_v_q;
	assign out_ch.out_byte = cur_q.bytes[idx_q];
	assign out_ch.kind = cur_q.kind;
	assign out_ch.error_code = cur_q.code;
	assign out_ch.last = at_end;

	always_ff @(posedge clk) begin
		if (pop) cur_q <= q_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_v_q <= 1'b0;
			idx_q <= 2'd0;
		end else if (pop) begin
			cur_v_q <= 1'b1;
			idx_q <= 2'd0;
		end else if (out_acc) begin
			if (at_end) begin
				cur_v_q <= 1'b0;
				idx_q <= 2'd0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

`ifndef SYNTHESIS
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		cur_v_q |-> idx_q <= cur_q.cnt_m1)
		else $error("serializer index past end of group");
	a_ctl_single: assert property (@(posedge clk) disable iff (!arst_n)
		cur_v_q && cur_q.kind != KIND_DATA |-> out_ch.last && out_ch.out_byte == 8'h00)
		else $error("close or error result not single and zero");
`endif

endmodule

/* sv/json_string_unescape_utf8.sv */
// channel   dir  handshake      payload
// in_ch     in   valid/ready    data_byte[7:0], text_end
// out_ch    out  valid/ready    out_byte[7:0], kind[1:0], error_code[2:0], last
//
// one input byte is taken every cycle while the group queue has room
// each byte makes 0 to 4 results; the serializer sends one result per cycle while
//   out_ch is ready, so the utf-8 bytes of a \u escape go out one after another
// a result passes through a queue entry and then the serializer register to out_ch
// arst_n clears parser state, queue pointers and the output valid at once
// output stalls back up through the queue; input stalls only when it is full
module json_string_unescape_utf8
	import jsu_pkg::*;
#(
	parameter int QUEUE_DEPTH = JSU_QDEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	jsu_in_if.sink    in_ch,
	jsu_out_if.source out_ch
);

	// parser to queue
	logic push;
	grp_t push_grp;
	logic q_full;

	// queue to serializer
	logic pop;
	grp_t pop_grp;
	logic q_empty;

	// front: string/escape/surrogate state machine, at most one group per request
	jsu_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.q_full (q_full),
		.push   (push),
		.grp    (push_grp)
	);

	// short queue of result groups, lets parser and serializer stall apart
	jsu_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (push_grp),
		.pop     (pop),
		.rd_data (pop_grp),
		.full    (q_full),
		.empty   (q_empty)
	);

	// back: walks each group out one result at a time, flags the last
	jsu_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_data  (pop_grp),
		.pop     (pop),
		.out_ch  (out_ch)
	);

endmodule

/* verif/json_string_unescape_utf8_tb.sv */
`timescale 1ns / 100ps

module json_string_unescape_utf8_tb;
	import jsu_pkg::*;

	// parser phases as the checker tracks them
	typedef enum logic [2:0] {
		P_WAIT,   // waiting for the opening quote
		P_STR,    // inside the string
		P_ESC,    // after a backslash
		P_HEX1,   // first \u escape digits
		P_BS,     // high surrogate held, backslash must follow
		P_U,      // high surrogate held, u must follow
		P_HEX2    // low surrogate digits
	} parse_phase_t;

	// one result as it should appear on the output channel
	typedef struct packed {
		logic [7:0] octet;
		kind_t      kind;
		err_t       code;
		logic       last;
	} decode_result_t;

	logic clk = 1'b0;
	logic arst_n;

	jsu_in_if  in_ch();
	jsu_out_if out_ch();

	json_string_unescape_utf8 u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	always #5 clk = ~clk;

	// decoder state mirrored by the checker
	parse_phase_t phase_q;
	logic [1:0]   hex_cnt;
	logic [15:0]  hex_acc;
	logic [15:0]  hi_surr;

	// results of the request being decoded, then all results still owed
	decode_result_t step_out[$];
	decode_result_t expected_decode[$];

	// random idling of each side, switched off for the back-to-back stretch
	bit idle_en;
	bit stall_en;

	int req_count;
	int results_seen;
	int closes_seen;
	int errors_seen;
	int fail_count;

	// ------------------------------------------------------------------
	// decoder prediction
	// ------------------------------------------------------------------

	function automatic void add_result(logic [7:0] o, kind_t k, err_t c);
		decode_result_t r;
		r.octet = o;
		r.kind  = k;
		r.code  = c;
		r.last  = 1'b0;
		step_out = {step_out, r};
	endfunction

	// any error drops the string and clears the escape state
	function automatic void parse_fail(err_t c);
		phase_q = P_WAIT;
		hex_cnt = '0;
		hex_acc = '0;
		hi_surr = '0;
		add_result(8'h00, KIND_ERR, c);
	endfunction

	function automatic int hex_nibble(logic [7:0] c);
		if (c >= "0" && c <= "9") return c - "0";
		if (c >= "a" && c <= "f") return c - "a" + 10;
		if (c >= "A" && c <= "F") return c - "A" + 10;
		return -1;
	endfunction

	// -1 bad digit, 1 four digits complete, 0 more to come
	function automatic int take_hex_digit(logic [7:0] c);
		int v;
		v = hex_nibble(c);
		if (v < 0) return -1;
		hex_acc = {hex_acc[11:0], v[3:0]};
		if (hex_cnt == 2'd3) begin
			hex_cnt = '0;
			return 1;
		end
		hex_cnt = hex_cnt + 2'd1;
		return 0;
	endfunction

	// code point to 1..4 utf-8 bytes
	function automatic void add_utf8(int cp);
		if (cp <= CP_MAX1) begin
			add_result(cp[7:0], KIND_DATA, ERR_NONE);
		end else if (cp <= CP_MAX2) begin
			add_result(LEAD2 | cp[10:6], KIND_DATA, ERR_NONE);
			add_result(CONT | cp[5:0], KIND_DATA, ERR_NONE);
		end else if (cp <= CP_MAX3) begin
			add_result(LEAD3 | cp[15:12], KIND_DATA, ERR_NONE);
			add_result(CONT | cp[11:6], KIND_DATA, ERR_NONE);
			add_result(CONT | cp[5:0], KIND_DATA, ERR_NONE);
		end else begin
			add_result(LEAD4 | cp[20:18], KIND_DATA, ERR_NONE);
			add_result(CONT | cp[17:12], KIND_DATA, ERR_NONE);
			add_result(CONT | cp[11:6], KIND_DATA, ERR_NONE);
			add_result(CONT | cp[5:0], KIND_DATA, ERR_NONE);
		end
	endfunction

	// works out the results of one accepted request and queues them
	function automatic void unescape_step(logic [7:0] c, logic eot);
		int         r;
		int         cp;
		logic [7:0] esc;
		bit         esc_ok;
		step_out.delete();
		if (phase_q == P_WAIT) begin
			// only a quote opens a string, anything else is reported
			if (!eot && c == CH_QUOTE) phase_q = P_STR;
			else parse_fail(ERR_NO_QUOTE);
		end else if (eot) begin
			parse_fail(ERR_END);
		end else begin
			case (phase_q)
				P_STR: begin
					if (c == CH_QUOTE) begin
						phase_q = P_WAIT;
						add_result(8'h00, KIND_CLOSE, ERR_NONE);
					end else if (c == CH_BSLASH) begin
						phase_q = P_ESC;
					end else begin
						add_result(c, KIND_DATA, ERR_NONE);
					end
				end
				P_ESC: begin
					esc_ok = 1'b1;
					esc    = c;
					case (c)
						CH_QUOTE, CH_BSLASH, CH_SLASH: esc = c;
						CH_LC_B: esc = 8'h08;
						CH_LC_F: esc = 8'h0C;
						CH_LC_N: esc = 8'h0A;
						CH_LC_R: esc = 8'h0D;
						CH_LC_T: esc = 8'h09;
						default: esc_ok = 1'b0;
					endcase
					if (c == CH_LC_U) begin
						phase_q = P_HEX1;
						hex_cnt = '0;
						hex_acc = '0;
					end else if (!esc_ok) begin
						parse_fail(ERR_UNK_ESC);
					end else begin
						phase_q = P_STR;
						add_result(esc, KIND_DATA, ERR_NONE);
					end
				end
				P_HEX1: begin
					r = take_hex_digit(c);
					if (r < 0) begin
						parse_fail(ERR_BAD_HEX);
					end else if (r > 0) begin
						if (hex_acc >= HI_SURR_LO && hex_acc <= HI_SURR_HI) begin
							// hold the high half until its partner arrives
							hi_surr = hex_acc;
							hex_acc = '0;
							phase_q = P_BS;
						end else begin
							// lone low surrogates fall through here too
							phase_q = P_STR;
							add_utf8(int'(hex_acc));
						end
					end
				end
				P_BS: begin
					if (c != CH_BSLASH) parse_fail(ERR_MISS_U);
					else phase_q = P_U;
				end
				P_U: begin
					if (c != CH_LC_U) begin
						parse_fail(ERR_MISS_U);
					end else begin
						phase_q = P_HEX2;
						hex_cnt = '0;
						hex_acc = '0;
					end
				end
				P_HEX2: begin
					r = take_hex_digit(c);
					if (r < 0) begin
						parse_fail(ERR_BAD_HEX);
					end else if (r > 0) begin
						if (hex_acc < LO_SURR_LO || hex_acc > LO_SURR_HI) begin
							parse_fail(ERR_BAD_LOW);
						end else begin
							cp = 'h10000 + ((int'(hi_surr) - int'(HI_SURR_LO)) << 10)
								+ (int'(hex_acc) - int'(LO_SURR_LO));
							phase_q = P_STR;
							hi_surr = '0;
							add_utf8(cp);
						end
					end
				end
				default: parse_fail(ERR_NO_QUOTE);
			endcase
		end
		// the final result of this request carries last
		if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1'b1;
		expected_decode = {expected_decode, step_out};
	endfunction

	// ------------------------------------------------------------------
	// request driving
	// ------------------------------------------------------------------

	// one request: optional random gap, then hold valid until ready
	task automatic send_req(input logic [7:0] b, input logic eot);
		if (idle_en) begin
			while ($urandom_range(99) < 13) begin
				in_ch.valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_ch.valid     <= 1'b1;
		in_ch.data_byte <= b;
		in_ch.text_end  <= eot;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		unescape_step(b, eot);
		req_count++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) send_req(s[i], 1'b0);
	endtask

	function automatic logic [7:0] hex_char(logic [3:0] n, bit upper);
		if (n < 4'd10) return "0" + n;
		return (upper ? "A" : "a") + (n - 4'd10);
	endfunction

	// \uXXXX with each digit in random case
	task automatic send_uescape(input logic [15:0] v);
		send_req(CH_BSLASH, 1'b0);
		send_req(CH_LC_U, 1'b0);
		for (int i = 3; i >= 0; i--)
			send_req(hex_char(v[i*4 +: 4], 1'($urandom_range(1))), 1'b0);
	endtask

	// holds off new requests until every owed result has come out
	task automatic wait_decode_drained();
		in_ch.valid <= 1'b0;
		while (expected_decode.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// one well-formed piece of string content
	task automatic send_piece();
		int          sel;
		logic [7:0]  b;
		logic [15:0] v;
		sel = $urandom_range(99);
		if (sel < 40) begin
			// plain byte, any value but the two that mean something
			b = 8'($urandom_range(255));
			if (b == CH_QUOTE || b == CH_BSLASH) b = b ^ 8'h01;
			send_req(b, 1'b0);
		end else if (sel < 60) begin
			send_req(CH_BSLASH, 1'b0);
			case ($urandom_range(7))
				0: send_req(CH_QUOTE, 1'b0);
				1: send_req(CH_BSLASH, 1'b0);
				2: send_req(CH_SLASH, 1'b0);
				3: send_req(CH_LC_B, 1'b0);
				4: send_req(CH_LC_F, 1'b0);
				5: send_req(CH_LC_N, 1'b0);
				6: send_req(CH_LC_R, 1'b0);
				default: send_req(CH_LC_T, 1'b0);
			endcase
		end else if (sel < 85) begin
			// bmp escape spread over the 1, 2 and 3 byte ranges and lone lows
			case ($urandom_range(3))
				0: v = 16'($urandom_range(16'h007F));
				1: v = 16'($urandom_range(16'h07FF, 16'h0080));
				2: v = 16'($urandom_range(16'hFFFF, 16'h0800));
				default: v = 16'($urandom_range(LO_SURR_HI, LO_SURR_LO));
			endcase
			if (v >= HI_SURR_LO && v <= HI_SURR_HI) v = v ^ 16'h1000;
			send_uescape(v);
		end else begin
			send_uescape(16'($urandom_range(HI_SURR_HI, HI_SURR_LO)));
			send_uescape(16'($urandom_range(LO_SURR_HI, LO_SURR_LO)));
		end
	endtask

	// one piece that breaks the string, by an end of text or somewhere along an escape
	task automatic send_broken_piece();
		int n;
		case ($urandom_range(5))
			0: send_req(8'($urandom_range(255)), 1'b1);
			1: begin
				send_req(CH_BSLASH, 1'b0);
				send_req(8'($urandom_range(255)), 1'b0);
			end
			2: begin
				send_req(CH_BSLASH, 1'b0);
				send_req(CH_LC_U, 1'b0);
				n = $urandom_range(3);
				for (int i = 0; i < n; i++)
					send_req(hex_char(4'($urandom_range(15)), 1'b0), 1'b0);
				send_req(8'($urandom_range(255)), 1'b0);
			end
			3: begin
				send_uescape(16'($urandom_range(HI_SURR_HI, HI_SURR_LO)));
				send_req(8'($urandom_range(255)), 1'b0);
			end
			4: begin
				send_uescape(16'($urandom_range(HI_SURR_HI, HI_SURR_LO)));
				send_req(CH_BSLASH, 1'b0);
				send_req(8'($urandom_range(255)), 1'b0);
			end
			default: begin
				// partner with any value, mostly not a low surrogate
				send_uescape(16'($urandom_range(HI_SURR_HI, HI_SURR_LO)));
				send_uescape(16'($urandom_range(16'hFFFF)));
			end
		endcase
	endtask

	// quoted string of random pieces, now and then broken or preceded by junk
	task automatic send_random_string(input bit allow_noise);
		int         n_pieces;
		int         broken_at;
		logic [7:0] junk;
		n_pieces  = $urandom_range(6);
		broken_at = -1;
		if (allow_noise && $urandom_range(99) < 15) broken_at = $urandom_range(n_pieces);
		if (allow_noise && $urandom_range(99) < 6) begin
			// junk outside any string, never a quote so the framing holds
			junk = 8'($urandom_range(255));
			if (junk == CH_QUOTE) junk = 8'hA2;
			send_req(junk, 1'($urandom_range(1)));
		end
		send_req(CH_QUOTE, 1'b0);
		for (int i = 0; i <= n_pieces; i++) begin
			if (i == broken_at) send_broken_piece();
			if (i < n_pieces) send_piece();
		end
		send_req(CH_QUOTE, 1'b0);
		// an end of text puts the parser back to waiting whatever happened
		if (broken_at >= 0) send_req(8'($urandom_range(255)), 1'b1);
	endtask

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	// bytes and end of text while no string is open
	task automatic test_outside_string();
		send_req("x", 1'b0);
		send_req(8'hFF, 1'b1);
	endtask

	// byte extremes, an escape, utf-8 of two, three and four bytes, pair and lone low
	task automatic test_escapes_and_utf8();
		send_text("\"");
		send_req(8'h00, 1'b0);
		send_req(8'hFF, 1'b0);
		send_text("\\/\\u00e9\\uD83D\\ude00\\uDFFF\\uFFFF\"");
	endtask

	// each error code but ERR_NO_QUOTE, with ERR_MISS_U from both the backslash and the u
	task automatic test_error_codes();
		send_text("\"\\q");
		send_text("\"\\u0g");
		send_text("\"\\uD800x");
		send_text("\"\\uDBFF\\x");
		send_text("\"\\uD800\\u0041");
		send_text("\"a");
		send_req(8'h00, 1'b1);
	endtask

	// random strings with gaps and stalls on both sides
	task automatic test_random_strings();
		int start;
		start    = req_count;
		idle_en  = 1'b1;
		stall_en = 1'b1;
		while (req_count - start < 40) send_random_string(1'b1);
		// let the output queue run dry before going on
		wait_decode_drained();
		while (req_count - start < 80) send_random_string(1'b1);
	endtask

	// long stretch at full rate, both sides always willing
	task automatic test_back_to_back();
		int start;
		start    = req_count;
		idle_en  = 1'b0;
		stall_en = 1'b0;
		while (req_count - start < 40) send_random_string(1'($urandom_range(1)));
		idle_en  = 1'b1;
		stall_en = 1'b1;
	endtask

	// ------------------------------------------------------------------
	// output side
	// ------------------------------------------------------------------

	// random backpressure on the results
	always @(posedge clk) begin
		out_ch.ready <= stall_en ? ($urandom_range(99) >= 13) : 1'b1;
	end

	// every result is checked against the oldest one owed
	always @(posedge clk) begin : check_decode
		decode_result_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			results_seen++;
			if (out_ch.kind == KIND_CLOSE) closes_seen++;
			if (out_ch.kind == KIND_ERR) errors_seen++;
			if (expected_decode.size() == 0) begin
				$error("result with nothing owed: out_byte %02h kind %0d error_code %0d",
					out_ch.out_byte, out_ch.kind, out_ch.error_code);
				fail_count++;
			end else begin
				want = expected_decode.pop_front();
				if (out_ch.out_byte !== want.octet) begin
					$error("out_byte: expected %02h, got %02h", want.octet, out_ch.out_byte);
					fail_count++;
				end
				if (out_ch.kind !== want.kind) begin
					$error("kind: expected %0d, got %0d", want.kind, out_ch.kind);
					fail_count++;
				end
				if (out_ch.error_code !== want.code) begin
					$error("error_code: expected %0d, got %0d", want.code, out_ch.error_code);
					fail_count++;
				end
				if (out_ch.last !== want.last) begin
					$error("last: expected %0d, got %0d", want.last, out_ch.last);
					fail_count++;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// sequence
	// ------------------------------------------------------------------

	initial begin
		arst_n          = 1'b0;
		in_ch.valid     = 1'b0;
		in_ch.data_byte = 8'h00;
		in_ch.text_end  = 1'b0;
		out_ch.ready    = 1'b0;
		phase_q         = P_WAIT;
		hex_cnt         = '0;
		hex_acc         = '0;
		hi_surr         = '0;
		idle_en         = 1'b1;
		stall_en        = 1'b1;
		req_count       = 0;
		results_seen    = 0;
		closes_seen     = 0;
		errors_seen     = 0;
		fail_count      = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_outside_string();
		test_escapes_and_utf8();
		test_error_codes();
		test_random_strings();
		test_back_to_back();

		// all requests in; wait for the tail to come out
		wait_decode_drained();
		repeat (8) @(posedge clk);

		$display("%0d requests decoded into %0d results: %0d strings closed, %0d errors",
			req_count, results_seen, closes_seen, errors_seen);
		$display("plain bytes, simple and \\u escapes, surrogate pairs, lone lows, all error codes");
		if (fail_count == 0) begin
			$display("json_string_unescape_utf8 test passed");
		end else begin
			$display("json_string_unescape_utf8 test failed");
		end
		$finish;
	end

	// hang guard, far beyond the slowest legal run
	initial begin
		#2000000;
		$display("json_string_unescape_utf8 test failed");
		$finish;
	end

endmodule
